### hdl/stlc_pkg.sv
`timescale 1ns / 1ps
// Shared types, character constants and character class functions for the
// socket table line counter. No dependencies.
package stlc_pkg;

    localparam int DEF_MAX_UID_CHARS = 8;
    localparam int DEF_TOTAL_WIDTH   = 16;

    localparam int UID_TEXT_WIDTH = 64;
    localparam int CFG_DATA_WIDTH = 64;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UID_TEXT        = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UID_LENGTH      = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UID_TOKEN_INDEX = 2'd2;

    localparam logic [63:0] UID_TEXT_RESET        = 64'd0;
    localparam logic [3:0]  UID_LENGTH_RESET      = 4'd1;
    localparam logic [4:0]  UID_TOKEN_INDEX_RESET = 5'd7;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [2:0] PORT_CHARS     = 3'd4;
    localparam logic [2:0] PORT_COUNT_MAX = 3'd5;
    localparam logic [5:0] TOKEN_MAX      = 6'd63;
    localparam logic [3:0] POS_MAX        = 4'd15;

    typedef struct packed {
        logic [7:0] character;
        logic       line_end;
        logic       sample_end;
    } in_word_t;

    typedef struct packed {
        logic        line_counted;
        logic [15:0] running_total;
        logic        sample_done;
    } out_word_t;

    typedef struct packed {
        logic listen_confirmed;
        logic pattern_failed;
    } listen_status_t;

    typedef struct packed {
        logic [63:0] uid_text;
        logic [3:0]  uid_length;
        logic [4:0]  uid_token_index;
    } uid_cfg_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_dig(c) || ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
            || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

endpackage

### hdl/stlc_pattern.sv
`timescale 1ns / 1ps
// Listening-local line pattern tracker, one character per step.
// Depends on stlc_pkg.
module stlc_pattern
    import stlc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     character,
    input  logic           line_end,
    output listen_status_t status
);

    typedef enum logic [11:0] {
        PH_LEAD     = 12'b0000_0000_0001,
        PH_HEAD     = 12'b0000_0000_0010,
        PH_SP1      = 12'b0000_0000_0100,
        PH_SP1_MORE = 12'b0000_0000_1000,
        PH_ZERO1    = 12'b0000_0001_0000,
        PH_PORT1    = 12'b0000_0010_0000,
        PH_SP2      = 12'b0000_0100_0000,
        PH_ZERO2    = 12'b0000_1000_0000,
        PH_PORT2    = 12'b0001_0000_0000,
        PH_SP3      = 12'b0010_0000_0000,
        PH_STATE    = 12'b0100_0000_0000,
        PH_TAIL     = 12'b1000_0000_0000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] port_count_reg, port_count_next;
    logic       failed_reg, failed_next;
    logic       pending_reg, pending_next;
    logic       confirmed_reg, confirmed_next;

    always_comb
    begin
        phase_next      = phase_reg;
        port_count_next = port_count_reg;
        failed_next     = failed_reg;
        pending_next    = pending_reg;
        confirmed_next  = confirmed_reg;
        if (!failed_reg)
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (!is_ws(character))
                    begin
                        if (is_dig(character)) phase_next = PH_HEAD;
                        else failed_next = 1'b1;
                    end
                end
                PH_HEAD:
                begin
                    if (!is_dig(character))
                    begin
                        if (character == CHAR_COLON) phase_next = PH_SP1;
                        else failed_next = 1'b1;
                    end
                end
                PH_SP1:
                begin
                    if (is_ws(character)) phase_next = PH_SP1_MORE;
                    else failed_next = 1'b1;
                end
                PH_SP1_MORE, PH_SP2:
                begin
                    if (!is_ws(character))
                    begin
                        if (character == CHAR_ZERO)
                            phase_next = (phase_reg == PH_SP1_MORE) ? PH_ZERO1 : PH_ZERO2;
                        else
                            failed_next = 1'b1;
                    end
                end
                PH_ZERO1, PH_ZERO2:
                begin
                    if (character != CHAR_ZERO)
                    begin
                        if (character == CHAR_COLON)
                        begin
                            port_count_next = '0;
                            phase_next = (phase_reg == PH_ZERO1) ? PH_PORT1 : PH_PORT2;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                end
                PH_PORT1, PH_PORT2:
                begin
                    if (is_alnum(character))
                    begin
                        if (port_count_reg < PORT_COUNT_MAX)
                            port_count_next = port_count_reg + 3'd1;
                    end
                    else if ((port_count_reg == PORT_CHARS) && is_ws(character))
                    begin
                        phase_next = (phase_reg == PH_PORT1) ? PH_SP2 : PH_SP3;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_SP3:
                begin
                    if (!is_ws(character))
                    begin
                        if (character == CHAR_ZERO) phase_next = PH_STATE;
                        else failed_next = 1'b1;
                    end
                end
                PH_STATE:
                begin
                    if ((character == CHAR_UPPER_A) || (character == CHAR_LOWER_A))
                    begin
                        pending_next = 1'b1;
                        phase_next   = PH_TAIL;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_TAIL:
                begin
                    if (pending_reg) confirmed_next = 1'b1;
                end
                default:
                begin
                    failed_next = 1'b1;
                end
            endcase
        end
    end

    assign status.listen_confirmed = confirmed_next;
    assign status.pattern_failed   = failed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            port_count_reg <= '0;
            failed_reg     <= 1'b0;
            pending_reg    <= 1'b0;
            confirmed_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (line_end)
            begin
                phase_reg      <= PH_LEAD;
                port_count_reg <= '0;
                failed_reg     <= 1'b0;
                pending_reg    <= 1'b0;
                confirmed_reg  <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                port_count_reg <= port_count_next;
                failed_reg     <= failed_next;
                pending_reg    <= pending_next;
                confirmed_reg  <= confirmed_next;
            end
        end
    end

endmodule

### hdl/stlc_token.sv
`timescale 1ns / 1ps
// Token splitter and uid comparator, one character per step.
// Depends on stlc_pkg.
module stlc_token
    import stlc_pkg::*;
#(
    parameter int MAX_UID_CHARS = DEF_MAX_UID_CHARS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] character,
    input  logic       line_end,
    input  uid_cfg_t   cfg,
    output logic       uid_match
);

    logic [5:0] token_count_reg, token_count_next;
    logic       inside_reg, inside_next;
    logic [3:0] pos_reg, pos_next;
    logic       match_reg, match_next;

    logic [3:0] eff_len;
    logic [5:0] index_ext;
    logic [5:0] target_count;
    logic [7:0] uid_byte;

    assign eff_len = (cfg.uid_length > 4'(MAX_UID_CHARS)) ? 4'(MAX_UID_CHARS)
                                                          : cfg.uid_length;
    assign index_ext    = {1'b0, cfg.uid_token_index};
    assign target_count = index_ext + 6'd1;

    always_comb
    begin
        token_count_next = token_count_reg;
        inside_next      = inside_reg;
        pos_next         = pos_reg;
        match_next       = match_reg;
        uid_byte         = '0;
        if (is_ws(character))
        begin
            if (inside_reg && (token_count_reg == target_count) && (pos_reg != eff_len))
                match_next = 1'b0;
            inside_next = 1'b0;
        end
        else
        begin
            if (!inside_reg)
            begin
                inside_next = 1'b1;
                if (token_count_reg == index_ext)
                begin
                    match_next = 1'b1;
                    pos_next   = '0;
                end
                if (token_count_reg < TOKEN_MAX)
                    token_count_next = token_count_reg + 6'd1;
            end
            if (token_count_next == target_count)
            begin
                uid_byte = cfg.uid_text[pos_next[2:0]*8 +: 8];
                if ((pos_next >= eff_len) || (uid_byte != character))
                    match_next = 1'b0;
                if (pos_next < POS_MAX)
                    pos_next = pos_next + 4'd1;
            end
        end
    end

    // At a line end an unfinished target token must have the full uid length.
    assign uid_match = match_next
        && !(inside_next && (token_count_next == target_count) && (pos_next != eff_len));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_count_reg <= '0;
            inside_reg      <= 1'b0;
            pos_reg         <= '0;
            match_reg       <= 1'b0;
        end
        else if (step)
        begin
            if (line_end)
            begin
                token_count_reg <= '0;
                inside_reg      <= 1'b0;
                pos_reg         <= '0;
                match_reg       <= 1'b0;
            end
            else
            begin
                token_count_reg <= token_count_next;
                inside_reg      <= inside_next;
                pos_reg         <= pos_next;
                match_reg       <= match_next;
            end
        end
    end

endmodule

### hdl/socket_table_line_counter_top.sv
`timescale 1ns / 1ps
// Socket table line counter: usage notes.
// The input channel (in_valid, in_ready, in_word) carries one text character per
// word, with line_end marking the last character of a line and sample_end marking
// the last line of a sample. Each word lands in an input register and is folded
// into the line state from there. Only a word with line_end set produces an
// output word (out_valid, out_ready, out_word): line_counted, the running total
// of counted lines in the sample, and sample_done, which copies sample_end.
// The result is registered as its line_end word is folded in. The block takes
// one word every cycle unless a line_end word waits on a stalled result; the rate
// is set by one state update per character between the input and result registers.
// When the receiver stalls, the result stays in the output register; words
// without line_end keep flowing, and the next line_end word waits in the input
// register until the result is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong between lines. Reset clears the line state, the total, both valid
// flags and the registers to their defaults (empty uid text, length one, token
// seven).
// Depends on stlc_pkg, stlc_pattern and stlc_token.
module socket_table_line_counter_top
    import stlc_pkg::*;
#(
    parameter int MAX_UID_CHARS = DEF_MAX_UID_CHARS,
    parameter int TOTAL_WIDTH   = DEF_TOTAL_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  in_word_t                   in_word,
    output logic                       out_valid,
    input  logic                       out_ready,
    output out_word_t                  out_word,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    uid_cfg_t       cfg_reg;
    logic           in_valid_reg, in_valid_next;
    in_word_t       in_word_reg;
    logic           out_valid_reg, out_valid_next;
    out_word_t      out_word_reg;
    logic [TOTAL_WIDTH-1:0] total_reg, total_next;
    logic [TOTAL_WIDTH-1:0] total_inc;
    logic [31:0]    total_ext;

    logic           out_free;
    logic           advance;
    logic           finish;
    logic           counted;
    listen_status_t listen;
    logic           uid_match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.uid_text        <= UID_TEXT_RESET;
            cfg_reg.uid_length      <= UID_LENGTH_RESET;
            cfg_reg.uid_token_index <= UID_TOKEN_INDEX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UID_TEXT:        cfg_reg.uid_text        <= cfg_data;
                REG_UID_LENGTH:      cfg_reg.uid_length      <= cfg_data[3:0];
                REG_UID_TOKEN_INDEX: cfg_reg.uid_token_index <= cfg_data[4:0];
                default:             ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!in_word_reg.line_end || out_free);
    assign finish   = advance && in_word_reg.line_end;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready) in_valid_next = 1'b1;
        else if (advance) in_valid_next = 1'b0;
    end

    stlc_pattern u_pattern (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .character (in_word_reg.character),
        .line_end  (in_word_reg.line_end),
        .status    (listen)
    );

    stlc_token #(
        .MAX_UID_CHARS (MAX_UID_CHARS)
    ) u_token (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .character (in_word_reg.character),
        .line_end  (in_word_reg.line_end),
        .cfg       (cfg_reg),
        .uid_match (uid_match)
    );

    assign counted   = !(listen.listen_confirmed && !listen.pattern_failed) && uid_match;
    assign total_inc = (counted && (total_reg != '1)) ? total_reg + 1'b1 : total_reg;
    assign total_ext = 32'(total_inc);

    always_comb
    begin
        total_next = total_reg;
        if (finish) total_next = in_word_reg.sample_end ? '0 : total_inc;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish) out_valid_next = 1'b1;
        else if (out_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) in_word_reg <= in_word;
        if (finish)
        begin
            out_word_reg.line_counted  <= counted;
            out_word_reg.running_total <= total_ext[15:0];
            out_word_reg.sample_done   <= in_word_reg.sample_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### hdl/stlc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the socket table line counter, bound to the top level.
// Depends on stlc_pkg and socket_table_line_counter_top.
module stlc_checker
    import stlc_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input out_word_t                  out_word
);

    logic [15:0] last_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_total_reg <= out_word.sample_done ? 16'd0 : out_word.running_total;
        end
    end

    // A stalled result holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result changed while stalled");

    // An empty output stage never blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // A line that did not count leaves the total where the last result put it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_word.line_counted
            |-> out_word.running_total == last_total_reg)
        else $error("total moved on an uncounted line");

    // No result can leave right after reset.
    assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
        else $error("result valid just after reset");

endmodule

bind socket_table_line_counter_top stlc_checker u_checker (.*);

### tb/stlc_count_checker.sv
`timescale 1ns / 1ps
// Result checker for the socket table line counter: tracks the uid registers,
// predicts each result word from the accepted input words and compares them.
// Depends on stlc_pkg.
module stlc_count_checker
    import stlc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  in_word_t                   in_word,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  out_word_t                  out_word,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output int unsigned                fail_count,
    output int unsigned                results_owed
);

    typedef enum logic [3:0] {
        SCAN_LEAD,
        SCAN_SLOT,
        SCAN_GAP_ONE,
        SCAN_GAP_ONE_MORE,
        SCAN_ZEROS_LOCAL,
        SCAN_PORT_LOCAL,
        SCAN_GAP_TWO,
        SCAN_ZEROS_REMOTE,
        SCAN_PORT_REMOTE,
        SCAN_GAP_THREE,
        SCAN_STATE,
        SCAN_TAIL
    } scan_phase_t;

    logic [63:0] uid_text;
    logic [3:0]  uid_len;
    logic [4:0]  uid_slot;

    scan_phase_t scan_phase;
    logic [2:0]  port_len;
    logic        shape_bad;
    logic        state_listen;
    logic        listen_seen;
    logic [5:0]  token_num;
    logic        in_token;
    logic [3:0]  token_pos;
    logic        uid_hit;
    logic [15:0] sample_count;

    out_word_t   expected_counts[$];

    assign results_owed = expected_counts.size();

    function automatic logic blank_char(input logic [7:0] c);
        return c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c inside {[CHAR_ZERO:CHAR_NINE]};
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return c inside {[CHAR_ZERO:CHAR_NINE], [CHAR_UPPER_A:CHAR_UPPER_Z],
                         [CHAR_LOWER_A:CHAR_LOWER_Z]};
    endfunction

    function automatic logic [3:0] uid_chars();
        return (uid_len > 4'(DEF_MAX_UID_CHARS)) ? 4'(DEF_MAX_UID_CHARS) : uid_len;
    endfunction

    function automatic logic at_uid_token();
        return in_token && (token_num == {1'b0, uid_slot} + 6'd1);
    endfunction

    task automatic clear_line();
        scan_phase   = SCAN_LEAD;
        port_len     = '0;
        shape_bad    = 1'b0;
        state_listen = 1'b0;
        listen_seen  = 1'b0;
        token_num    = '0;
        in_token     = 1'b0;
        token_pos    = '0;
        uid_hit      = 1'b0;
    endtask

    task automatic port_step(input logic [7:0] c, input scan_phase_t after);
        if (word_char(c))
        begin
            if (port_len < PORT_COUNT_MAX)
                port_len = port_len + 3'd1;
        end
        else if (port_len == PORT_CHARS && blank_char(c))
            scan_phase = after;
        else
            shape_bad = 1'b1;
    endtask

    task automatic shape_step(input logic [7:0] c);
        if (!shape_bad)
        begin
            case (scan_phase)
                SCAN_LEAD:
                    if (digit_char(c))
                        scan_phase = SCAN_SLOT;
                    else if (!blank_char(c))
                        shape_bad = 1'b1;
                SCAN_SLOT:
                    if (c == CHAR_COLON)
                        scan_phase = SCAN_GAP_ONE;
                    else if (!digit_char(c))
                        shape_bad = 1'b1;
                SCAN_GAP_ONE:
                    if (blank_char(c))
                        scan_phase = SCAN_GAP_ONE_MORE;
                    else
                        shape_bad = 1'b1;
                SCAN_GAP_ONE_MORE, SCAN_GAP_TWO:
                    if (c == CHAR_ZERO)
                        scan_phase = (scan_phase == SCAN_GAP_ONE_MORE) ?
                            SCAN_ZEROS_LOCAL : SCAN_ZEROS_REMOTE;
                    else if (!blank_char(c))
                        shape_bad = 1'b1;
                SCAN_ZEROS_LOCAL, SCAN_ZEROS_REMOTE:
                    if (c == CHAR_COLON)
                    begin
                        port_len = '0;
                        scan_phase = (scan_phase == SCAN_ZEROS_LOCAL) ?
                            SCAN_PORT_LOCAL : SCAN_PORT_REMOTE;
                    end
                    else if (c != CHAR_ZERO)
                        shape_bad = 1'b1;
                SCAN_PORT_LOCAL:
                    port_step(c, SCAN_GAP_TWO);
                SCAN_PORT_REMOTE:
                    port_step(c, SCAN_GAP_THREE);
                SCAN_GAP_THREE:
                    if (c == CHAR_ZERO)
                        scan_phase = SCAN_STATE;
                    else if (!blank_char(c))
                        shape_bad = 1'b1;
                SCAN_STATE:
                    if (c == CHAR_UPPER_A || c == CHAR_LOWER_A)
                    begin
                        state_listen = 1'b1;
                        scan_phase = SCAN_TAIL;
                    end
                    else
                        shape_bad = 1'b1;
                SCAN_TAIL:
                    if (state_listen)
                        listen_seen = 1'b1;
                default:
                    shape_bad = 1'b1;
            endcase
        end
    endtask

    task automatic close_token();
        if (at_uid_token() && token_pos != uid_chars())
            uid_hit = 1'b0;
    endtask

    task automatic token_step(input logic [7:0] c);
        if (blank_char(c))
        begin
            close_token();
            in_token = 1'b0;
        end
        else
        begin
            if (!in_token)
            begin
                in_token = 1'b1;
                if (token_num == {1'b0, uid_slot})
                begin
                    uid_hit = 1'b1;
                    token_pos = '0;
                end
                if (token_num < TOKEN_MAX)
                    token_num = token_num + 6'd1;
            end
            if (at_uid_token())
            begin
                if (token_pos >= uid_chars() || uid_text[{token_pos[2:0], 3'b000} +: 8] != c)
                    uid_hit = 1'b0;
                if (token_pos < POS_MAX)
                    token_pos = token_pos + 4'd1;
            end
        end
    endtask

    task automatic predict_line_count(input in_word_t w);
        out_word_t r;
        logic      counted;
        shape_step(w.character);
        token_step(w.character);
        if (w.line_end)
        begin
            close_token();
            counted = !(listen_seen && !shape_bad) && uid_hit;
            if (counted && sample_count != '1)
                sample_count = sample_count + 16'd1;
            r.line_counted  = counted;
            r.running_total = sample_count;
            r.sample_done   = w.sample_end;
            expected_counts.push_back(r);
            clear_line();
            if (w.sample_end)
                sample_count = '0;
        end
    endtask

    task automatic check_count(input out_word_t got);
        out_word_t want;
        if (expected_counts.size() == 0)
        begin
            fail_count++;
            $display("%0t: result word with none expected: expected none, actual %h",
                     $time, got);
        end
        else
        begin
            want = expected_counts.pop_front();
            if (got.line_counted !== want.line_counted)
            begin
                fail_count++;
                $display("%0t: line_counted mismatch: expected %0d, actual %0d",
                         $time, want.line_counted, got.line_counted);
            end
            if (got.running_total !== want.running_total)
            begin
                fail_count++;
                $display("%0t: running_total mismatch: expected %0d, actual %0d",
                         $time, want.running_total, got.running_total);
            end
            if (got.sample_done !== want.sample_done)
            begin
                fail_count++;
                $display("%0t: sample_done mismatch: expected %0d, actual %0d",
                         $time, want.sample_done, got.sample_done);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uid_text     = UID_TEXT_RESET;
            uid_len      = UID_LENGTH_RESET;
            uid_slot     = UID_TOKEN_INDEX_RESET;
            sample_count = '0;
            fail_count   = 0;
            clear_line();
            expected_counts.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_count(out_word);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_UID_TEXT:        uid_text = cfg_data[63:0];
                    REG_UID_LENGTH:      uid_len  = cfg_data[3:0];
                    REG_UID_TOKEN_INDEX: uid_slot = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_line_count(in_word);
        end
    end

endmodule

### tb/tb_socket_table_line_counter_top.sv
`timescale 1ns / 1ps
// Testbench top for the socket table line counter: drives socket-table text,
// uid register settings and output stalls, and reports the verdict.
// Depends on stlc_pkg, socket_table_line_counter_top and stlc_count_checker.
module tb_socket_table_line_counter_top;
    import stlc_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 6;
    localparam int RANDOM_WORDS     = 1850;
    localparam int MIN_RANDOM_LINES = 60;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    in_word_t                   in_word;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    out_word_t                  out_word;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    int unsigned                fail_count;
    int unsigned                results_owed;

    bit          steady;
    int unsigned words_sent;
    int unsigned stall_cycles = 0;
    logic [63:0] gen_uid_text;
    logic [3:0]  gen_uid_len;
    logic [4:0]  gen_uid_slot;
    logic [7:0]  line_bytes[$];

    socket_table_line_counter_top u_top (.*);

    stlc_count_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [7:0] any_blank();
        return ($urandom_range(0, 3) != 0) ? CHAR_SPACE : 8'($urandom_range(9, 13));
    endfunction

    function automatic logic [7:0] hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10)
            return CHAR_ZERO + 8'(k);
        if (k < 16)
            return CHAR_UPPER_A + 8'(k - 10);
        return CHAR_LOWER_A + 8'(k - 16);
    endfunction

    function automatic logic [7:0] alnum_char();
        int k;
        k = $urandom_range(0, 61);
        if (k < 10)
            return CHAR_ZERO + 8'(k);
        if (k < 36)
            return CHAR_UPPER_A + 8'(k - 10);
        return CHAR_LOWER_A + 8'(k - 36);
    endfunction

    function automatic logic [7:0] visible_byte();
        return 8'($urandom_range(33, 255));
    endfunction

    function automatic logic [63:0] random_uid();
        logic [63:0] t;
        int          k;
        int          r;
        for (k = 0; k < 8; k++)
        begin
            r = $urandom_range(0, 19);
            if (r < 12)
                t[8*k +: 8] = CHAR_ZERO + 8'($urandom_range(0, 9));
            else if (r < 17)
                t[8*k +: 8] = alnum_char();
            else
                t[8*k +: 8] = visible_byte();
        end
        return t;
    endfunction

    task automatic put_address();
        int n;
        if ($urandom_range(0, 9) < 7)
            repeat ($urandom_range(1, 8)) line_bytes.push_back(CHAR_ZERO);
        else
            repeat ($urandom_range(1, 8)) line_bytes.push_back(hex_char());
        line_bytes.push_back(($urandom_range(0, 19) == 0) ? hex_char() : CHAR_COLON);
        n = ($urandom_range(0, 4) != 0) ? 4 : $urandom_range(1, 7);
        repeat (n)
            line_bytes.push_back(($urandom_range(0, 29) == 0) ? visible_byte() : hex_char());
    endtask

    task automatic put_uid_token();
        int         len;
        int         pick;
        int         n;
        int         k;
        logic [7:0] c;
        len  = (gen_uid_len > 8) ? 8 : gen_uid_len;
        pick = $urandom_range(0, 9);
        if (len == 0 || pick == 9)
            repeat ($urandom_range(1, 20)) line_bytes.push_back(alnum_char());
        else
        begin
            n = (pick == 6 && len > 1) ? len - 1 : len;
            for (k = 0; k < n; k++)
            begin
                c = gen_uid_text[8*k +: 8];
                if (pick == 8 && k == n - 1)
                    c = c ^ 8'($urandom_range(1, 255));
                line_bytes.push_back(c);
            end
            if (pick == 7)
                line_bytes.push_back(alnum_char());
        end
    endtask

    task automatic build_socket_line();
        int last_tok;
        int k;
        int r;
        repeat ($urandom_range(0, 3)) line_bytes.push_back(any_blank());
        last_tok = ((gen_uid_slot > 3) ? gen_uid_slot : 3) + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0)
            last_tok = $urandom_range(0, last_tok);
        for (k = 0; k <= last_tok; k++)
        begin
            if (k > 0)
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
                    line_bytes.push_back(any_blank());
            if (k == gen_uid_slot)
                put_uid_token();
            else if (k == 0)
            begin
                repeat ($urandom_range(1, 3))
                    line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                line_bytes.push_back(($urandom_range(0, 19) == 0) ? alnum_char() : CHAR_COLON);
            end
            else if (k <= 2)
                put_address();
            else if (k == 3)
            begin
                line_bytes.push_back(($urandom_range(0, 9) == 0) ? hex_char() : CHAR_ZERO);
                r = $urandom_range(0, 19);
                if (r < 8)
                    line_bytes.push_back(CHAR_UPPER_A);
                else if (r < 13)
                    line_bytes.push_back(CHAR_LOWER_A);
                else
                    line_bytes.push_back(hex_char());
                if ($urandom_range(0, 2) == 0)
                    line_bytes.push_back(hex_char());
            end
            else
                repeat ($urandom_range(1, 4))
                    line_bytes.push_back(($urandom_range(0, 19) == 0) ?
                                         visible_byte() : alnum_char());
        end
        if ($urandom_range(0, 3) == 0)
            line_bytes.push_back(any_blank());
    endtask

    task automatic build_line();
        int r;
        line_bytes.delete();
        r = $urandom_range(0, 19);
        if (r < 16)
            build_socket_line();
        else if (r < 18)
            repeat ($urandom_range(1, 24)) line_bytes.push_back(8'($urandom_range(0, 255)));
        else if (r == 18)
            repeat ($urandom_range(64, 70))
            begin
                line_bytes.push_back(alnum_char());
                line_bytes.push_back(any_blank());
            end
        else
            repeat ($urandom_range(1, 2)) line_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic load_text(input string s);
        int k;
        line_bytes.delete();
        for (k = 0; k < s.len(); k++)
            line_bytes.push_back(s[k]);
    endtask

    task automatic send_word(input in_word_t w);
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    task automatic send_line(input logic last_in_sample);
        in_word_t w;
        int       k;
        for (k = 0; k < line_bytes.size(); k++)
        begin
            w.character  = line_bytes[k];
            w.line_end   = (k == line_bytes.size() - 1);
            w.sample_end = w.line_end ? last_in_sample : ($urandom_range(0, 7) == 0);
            send_word(w);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_uid(input logic [63:0] text, input logic [3:0] len,
                            input logic [4:0] slot, input bit spare);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_we <= 1'b1;
        if (spare)
        begin
            cfg_index <= REG_SPARE;
            cfg_data  <= junk;
            @(posedge clk);
        end
        cfg_index <= REG_UID_TEXT;
        cfg_data  <= text;
        @(posedge clk);
        cfg_index <= REG_UID_LENGTH;
        cfg_data  <= {junk[63:4], len};
        @(posedge clk);
        cfg_index <= REG_UID_TOKEN_INDEX;
        cfg_data  <= {junk[63:5], slot};
        @(posedge clk);
        cfg_we <= 1'b0;
        gen_uid_text = text;
        gen_uid_len  = len;
        gen_uid_slot = slot;
    endtask

    initial
    begin
        int          phase;
        int unsigned random_start;
        int unsigned phase_start;
        int          budget;
        int          random_lines;
        logic [3:0]  len;
        logic [4:0]  slot;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_word      = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_UID_TEXT;
        cfg_data     = '0;
        steady       = 1'b0;
        words_sent   = 0;
        gen_uid_text = UID_TEXT_RESET;
        gen_uid_len  = UID_LENGTH_RESET;
        gen_uid_slot = UID_TOKEN_INDEX_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The default uid is a single zero byte in token seven.
        load_text("a b c d e f g ");
        line_bytes.push_back(8'h00);
        send_line(1'b0);
        line_bytes = {8'hFF};
        send_line(1'b1);
        line_bytes = {CHAR_CR};
        send_line(1'b0);
        settle();

        phase        = 0;
        random_lines = 0;
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS || random_lines < MIN_RANDOM_LINES)
        begin
            len  = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, 8)) : 4'($urandom);
            slot = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 9)) : 5'($urandom);
            case (phase)
                0: load_uid(64'h3030_3031, 4'd4, 5'd7, 1'b0);
                1: load_uid('1, 4'd8, 5'd31, 1'b1);
                2: load_uid(random_uid(), 4'd0, 5'd0, 1'b0);
                3: load_uid(random_uid(), 4'd15, 5'd3, 1'b0);
                4: load_uid(random_uid(), 4'($urandom_range(1, 8)), 5'($urandom_range(0, 9)),
                            1'b0);
                default: load_uid(random_uid(), len, slot, $urandom_range(0, 3) == 0);
            endcase
            steady      = (phase == 4);
            phase_start = words_sent;
            budget      = $urandom_range(150, 300);
            while (words_sent - phase_start < budget)
            begin
                build_line();
                send_line($urandom_range(0, 7) == 0);
                random_lines++;
            end
            settle();
            phase++;
        end

        steady = 1'b1;
        load_uid(64'h78, 4'd1, 5'd0, 1'b0);
        load_text("x");
        send_line(1'b0);
        send_line(1'b1);
        settle();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
